/* src/load_based_dvfs_governor_assert.svh */
// Assertion macros shared by the governor modules.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef LOAD_BASED_DVFS_GOVERNOR_ASSERT_SVH
`define LOAD_BASED_DVFS_GOVERNOR_ASSERT_SVH

// Consequence checked in the same cycle as the antecedent.
`define LBDG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define LBDG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lbdg_pkg.sv */
// Shared types, codes and constants of the load-based DVFS governor.
// No dependencies; used by every module of the block.
package lbdg_pkg;

    localparam int FREQ_W  = 22;
    localparam int TIME_W  = 32;
    localparam int TASK_W  = 8;
    localparam int CMD_W   = 3;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 3;
    localparam int LOAD_W  = 7;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 32;

    // Divider: dividend wide enough for 100 times a 32-bit delta.
    localparam int DIVD_W    = 39;
    localparam int DIV_STEPS = DIVD_W;
    localparam int CNT_W     = 6;

    // Division by 100 of a product below 2^29 by reciprocal multiplication.
    // The rounded-up reciprocal of 2^35 / 100 is exact over that range.
    localparam int                PROD_W    = 29;
    localparam int                RECIP_SH  = 35;
    localparam logic [PROD_W-1:0] RECIP_100 = 29'd343597384;

    localparam logic [FREQ_W-1:0] RST_POLICY_MIN  = 22'd0;
    localparam logic [FREQ_W-1:0] RST_POLICY_MAX  = 22'd4194303;
    localparam logic [FREQ_W-1:0] RST_RAMP_THRESH = 22'd614400;
    localparam logic [FREQ_W-1:0] RST_RESUME_FREQ = 22'd518400;
    localparam logic [FREQ_W-1:0] RST_SUSP_FREQ   = 22'd352000;
    localparam logic [TIME_W-1:0] RST_MIN_DWELL   = 32'd44000;
    localparam logic [FREQ_W-1:0] RST_LOW_GUARD   = 22'd400000;

    localparam logic [LOAD_W-1:0] FULL_LOAD = 7'd100;

    localparam logic REL_L = 1'b0;
    localparam logic REL_H = 1'b1;

    localparam logic [1:0] WQ_NONE = 2'd0;
    localparam logic [1:0] WQ_UP   = 2'd1;
    localparam logic [1:0] WQ_DOWN = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE    = 3'd0,
        CMD_APPLY     = 3'd1,
        CMD_IDLE_EXIT = 3'd2,
        CMD_SUSPEND   = 3'd3,
        CMD_RESUME    = 3'd4,
        CMD_LIMITS    = 3'd5
    } cmd_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_POLICY_MIN  = 3'd0,
        CFG_POLICY_MAX  = 3'd1,
        CFG_RAMP_THRESH = 3'd2,
        CFG_RESUME_FREQ = 3'd3,
        CFG_SUSP_FREQ   = 3'd4,
        CFG_MIN_DWELL   = 3'd5,
        CFG_LOW_GUARD   = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL1,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
        logic mul1;
        logic mul2;
        logic div_step;
        logic recip;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scale;
        logic out_busy;
    } dp_status_t;

endpackage

/* src/lbdg_ctrl.sv */
// Controller state machine of the governor: sequences capture, commit and
// the two multiply/divide passes of the load scaling. Uses lbdg_pkg.
`include "load_based_dvfs_governor_assert.svh"

module lbdg_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lbdg_pkg::dp_status_t  status,
    output lbdg_pkg::ctrl_cmd_t   ctl
);

    lbdg_pkg::state_t              state_reg, state_next;
    logic [lbdg_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          cnt_last;

    assign cnt_last = (cnt_reg == lbdg_pkg::CNT_W'(lbdg_pkg::DIV_STEPS - 1));

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lbdg_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lbdg_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = lbdg_pkg::ST_EXEC;
                end
            end
            lbdg_pkg::ST_EXEC:
            begin
                if (status.need_scale)
                begin
                    state_next = lbdg_pkg::ST_MUL1;
                end
                else if (!status.out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = lbdg_pkg::ST_IDLE;
                end
            end
            lbdg_pkg::ST_MUL1:
            begin
                ctl.mul1   = 1'b1;
                cnt_next   = '0;
                state_next = lbdg_pkg::ST_DIV1;
            end
            lbdg_pkg::ST_DIV1:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = lbdg_pkg::ST_MUL2;
                end
            end
            lbdg_pkg::ST_MUL2:
            begin
                ctl.mul2   = 1'b1;
                state_next = lbdg_pkg::ST_DIV2;
            end
            lbdg_pkg::ST_DIV2:
            begin
                // Division by 100 in one reciprocal multiply.
                ctl.recip  = 1'b1;
                state_next = lbdg_pkg::ST_FIN;
            end
            lbdg_pkg::ST_FIN:
            begin
                if (!status.out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = lbdg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbdg_pkg::ST_IDLE;
            end
        endcase
    end

    `LBDG_ASSERT_SAME(a_commit_free, ctl.commit, !status.out_busy, "commit into a full output")
    `LBDG_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == lbdg_pkg::ST_EXEC, "no exec after accept")
    `LBDG_ASSERT_NEXT(a_div1_done, state_reg == lbdg_pkg::ST_DIV1 && cnt_last, state_reg == lbdg_pkg::ST_MUL2, "first division overran")

endmodule

/* src/lbdg_datapath.sv */
// Datapath of the governor: configuration, governor state, event decision,
// serial divider for the load and the output register. Uses lbdg_pkg.
`include "load_based_dvfs_governor_assert.svh"

module lbdg_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lbdg_pkg::IDX_W-1:0]       cfg_index,
    input  logic [lbdg_pkg::CFG_W-1:0]       cfg_data,
    input  logic [lbdg_pkg::IN_W-1:0]        in_data,
    input  logic [lbdg_pkg::CMD_W-1:0]       in_user,
    input  lbdg_pkg::ctrl_cmd_t              ctl,
    output lbdg_pkg::dp_status_t             status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lbdg_pkg::OUT_W-1:0]       out_data
);

    localparam int FW = lbdg_pkg::FREQ_W;
    localparam int TW = lbdg_pkg::TIME_W;
    localparam int DW = lbdg_pkg::DIVD_W;
    localparam int PW = lbdg_pkg::PROD_W;

    // Configuration registers.
    logic [FW-1:0] pmin_reg, pmax_reg, rth_reg, resf_reg, susf_reg, guard_reg;
    logic [TW-1:0] dwell_reg;

    // Captured event.
    lbdg_pkg::cmd_t               cmd_reg;
    logic [TW-1:0]                idle_reg, wall_reg;
    logic [lbdg_pkg::TASK_W-1:0]  tasks_reg;
    logic [FW-1:0]                cur_reg;

    // Governor state.
    logic          ramp_reg, ramp_next;
    logic [FW-1:0] tgt_reg, tgt_next;
    logic          susp_reg, susp_next;
    logic [TW-1:0] isnap_reg, isnap_next;
    logic [TW-1:0] ies_reg, ies_next;
    logic [TW-1:0] cs_reg, cs_next;
    logic [TW-1:0] cis_reg, cis_next;
    logic          armed_reg, armed_next;
    logic          pend_reg, pend_next;

    // Divider.
    logic [TW-1:0]   rem_reg;
    logic [DW-1:0]   quo_reg;
    logic [TW-1:0]   dvs_reg;
    logic [TW:0]     div_trial;
    logic            div_fit;
    logic [2*PW-1:0] recip_prod;

    // Output register.
    logic                        ov_reg;
    logic [lbdg_pkg::OUT_W-1:0]  od_reg;

    // Decision results.
    logic          rv, rel, rearm, fast;
    logic [FW-1:0] rf, scaled, fast_tgt;
    logic [1:0]    wq;
    logic [TW-1:0] dwall, didle;
    logic [lbdg_pkg::LOAD_W-1:0] load;

    assign dwall    = wall_reg - cs_reg;
    assign didle    = idle_reg - cis_reg;
    assign scaled   = quo_reg[FW-1:0];
    assign fast     = !susp_reg && (tgt_reg >= rth_reg || tgt_reg == pmax_reg);
    assign fast_tgt = (cur_reg < guard_reg) ? resf_reg : tgt_reg;

    // Load percentage from the first division, with the two corner cases.
    always_comb
    begin
        if (dwall == '0)
            load = lbdg_pkg::FULL_LOAD;
        else if (didle >= dwall)
            load = '0;
        else
            load = quo_reg[lbdg_pkg::LOAD_W-1:0];
    end

    assign status.need_scale = (cmd_reg == lbdg_pkg::CMD_APPLY) && pend_reg && !fast
                             && (!susp_reg || tgt_reg <= susf_reg);
    assign status.out_busy   = ov_reg && !out_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmin_reg  <= lbdg_pkg::RST_POLICY_MIN;
            pmax_reg  <= lbdg_pkg::RST_POLICY_MAX;
            rth_reg   <= lbdg_pkg::RST_RAMP_THRESH;
            resf_reg  <= lbdg_pkg::RST_RESUME_FREQ;
            susf_reg  <= lbdg_pkg::RST_SUSP_FREQ;
            dwell_reg <= lbdg_pkg::RST_MIN_DWELL;
            guard_reg <= lbdg_pkg::RST_LOW_GUARD;
        end
        else if (cfg_we)
        begin
            case (lbdg_pkg::cfg_idx_t'(cfg_index))
                lbdg_pkg::CFG_POLICY_MIN:  pmin_reg  <= cfg_data[FW-1:0];
                lbdg_pkg::CFG_POLICY_MAX:  pmax_reg  <= cfg_data[FW-1:0];
                lbdg_pkg::CFG_RAMP_THRESH: rth_reg   <= cfg_data[FW-1:0];
                lbdg_pkg::CFG_RESUME_FREQ: resf_reg  <= cfg_data[FW-1:0];
                lbdg_pkg::CFG_SUSP_FREQ:   susf_reg  <= cfg_data[FW-1:0];
                lbdg_pkg::CFG_MIN_DWELL:   dwell_reg <= cfg_data[TW-1:0];
                lbdg_pkg::CFG_LOW_GUARD:   guard_reg <= cfg_data[FW-1:0];
                default:                   ;
            endcase
        end
    end

    // Event capture.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= lbdg_pkg::cmd_t'(in_user);
            idle_reg  <= in_data[31:0];
            wall_reg  <= in_data[63:32];
            tasks_reg <= in_data[71:64];
            cur_reg   <= in_data[93:72];
        end
    end

    // Restoring divider for the load, one quotient bit per cycle; the final
    // division by 100 is a reciprocal multiply of the scaled product.
    assign div_trial  = {rem_reg, quo_reg[DW-1]};
    assign div_fit    = (div_trial >= {1'b0, dvs_reg});
    assign recip_prod = quo_reg[PW-1:0] * lbdg_pkg::RECIP_100;

    always_ff @(posedge clk)
    begin
        if (ctl.mul1)
        begin
            quo_reg <= DW'((dwall - didle) * lbdg_pkg::FULL_LOAD);
            rem_reg <= '0;
            dvs_reg <= dwall;
        end
        else if (ctl.mul2)
        begin
            quo_reg <= DW'(cur_reg * load);
        end
        else if (ctl.recip)
        begin
            quo_reg <= DW'(recip_prod[2*PW-1:lbdg_pkg::RECIP_SH]);
        end
        else if (ctl.div_step)
        begin
            rem_reg <= div_fit ? TW'(div_trial - {1'b0, dvs_reg}) : div_trial[TW-1:0];
            quo_reg <= {quo_reg[DW-2:0], div_fit};
        end
    end

    // Event decision.
    always_comb
    begin
        ramp_next  = ramp_reg;
        tgt_next   = tgt_reg;
        susp_next  = susp_reg;
        isnap_next = isnap_reg;
        ies_next   = ies_reg;
        cs_next    = cs_reg;
        cis_next   = cis_reg;
        armed_next = armed_reg;
        pend_next  = pend_reg;
        rv    = 1'b0;
        rf    = '0;
        rel   = lbdg_pkg::REL_L;
        wq    = lbdg_pkg::WQ_NONE;
        rearm = 1'b0;
        case (cmd_reg)
            lbdg_pkg::CMD_SAMPLE:
            begin
                armed_next = 1'b0;
                if (wall_reg != ies_reg)
                begin
                    if (idle_reg == isnap_reg)
                    begin
                        // Busy since the last snapshot: ramp up.
                        if (cur_reg != pmax_reg && tasks_reg != '0)
                        begin
                            if (pmax_reg > rth_reg)
                            begin
                                ramp_next = !ramp_reg;
                                tgt_next  = ramp_reg ? pmax_reg : rth_reg;
                            end
                            else
                            begin
                                tgt_next = pmax_reg;
                            end
                            wq        = pend_reg ? lbdg_pkg::WQ_NONE : lbdg_pkg::WQ_UP;
                            pend_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ramp_next = 1'b0;
                        if (tasks_reg != '0)
                        begin
                            isnap_next = idle_reg;
                            ies_next   = wall_reg;
                            armed_next = 1'b1;
                            rearm      = 1'b1;
                        end
                        if (cur_reg != pmin_reg && dwall >= dwell_reg)
                        begin
                            tgt_next  = pmin_reg;
                            wq        = pend_reg ? lbdg_pkg::WQ_NONE : lbdg_pkg::WQ_DOWN;
                            pend_next = 1'b1;
                        end
                    end
                end
            end
            lbdg_pkg::CMD_APPLY:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    cis_next  = idle_reg;
                    cs_next   = wall_reg;
                    if (fast)
                    begin
                        tgt_next = fast_tgt;
                        if (tasks_reg == 8'd1)
                        begin
                            // Single task: drop the work without new stamps.
                            cis_next = cis_reg;
                            cs_next  = cs_reg;
                        end
                        else
                        begin
                            rv  = 1'b1;
                            rf  = fast_tgt;
                            rel = lbdg_pkg::REL_H;
                        end
                    end
                    else if (!susp_reg)
                    begin
                        tgt_next = scaled;
                        rv       = 1'b1;
                        rf       = scaled;
                        rel      = lbdg_pkg::REL_L;
                    end
                    else if (tgt_reg > susf_reg)
                    begin
                        rv  = 1'b1;
                        rf  = susf_reg;
                        rel = lbdg_pkg::REL_H;
                    end
                    else
                    begin
                        tgt_next = scaled;
                        if (scaled < cur_reg)
                        begin
                            rv  = 1'b1;
                            rf  = scaled;
                            rel = lbdg_pkg::REL_H;
                        end
                    end
                end
            end
            lbdg_pkg::CMD_IDLE_EXIT:
            begin
                if (!armed_reg)
                begin
                    isnap_next = idle_reg;
                    ies_next   = wall_reg;
                    armed_next = 1'b1;
                    rearm      = 1'b1;
                end
            end
            lbdg_pkg::CMD_SUSPEND:
            begin
                susp_next = 1'b1;
                rv        = 1'b1;
                rf        = susf_reg;
                rel       = lbdg_pkg::REL_H;
            end
            lbdg_pkg::CMD_RESUME:
            begin
                susp_next = 1'b0;
                rv        = 1'b1;
                rf        = resf_reg;
                rel       = lbdg_pkg::REL_L;
            end
            lbdg_pkg::CMD_LIMITS:
            begin
                if (pmax_reg < cur_reg)
                begin
                    rv  = 1'b1;
                    rf  = pmax_reg;
                    rel = lbdg_pkg::REL_H;
                end
                else if (pmin_reg > cur_reg)
                begin
                    rv  = 1'b1;
                    rf  = pmin_reg;
                    rel = lbdg_pkg::REL_L;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Governor state update on commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg  <= 1'b0;
            tgt_reg   <= '0;
            susp_reg  <= 1'b0;
            isnap_reg <= '0;
            ies_reg   <= '0;
            cs_reg    <= '0;
            cis_reg   <= '0;
            armed_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (ctl.commit)
        begin
            ramp_reg  <= ramp_next;
            tgt_reg   <= tgt_next;
            susp_reg  <= susp_next;
            isnap_reg <= isnap_next;
            ies_reg   <= ies_next;
            cs_reg    <= cs_next;
            cis_reg   <= cis_next;
            armed_reg <= armed_next;
            pend_reg  <= pend_next;
        end
    end

    // Output register: one beat per committed event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            od_reg <= {5'd0, rearm, wq, rel, rf, rv};
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    `LBDG_ASSERT_NEXT(a_commit_shows, ctl.commit, ov_reg, "committed result not shown")
    `LBDG_ASSERT_SAME(a_valid_source, $rose(ov_reg), $past(ctl.commit), "result without commit")
    `LBDG_ASSERT_NEXT(a_apply_clears, ctl.commit && cmd_reg == lbdg_pkg::CMD_APPLY, !pend_reg, "apply left work pending")

endmodule

/* src/load_based_dvfs_governor.sv */
// Load-based DVFS governor: one event beat in, one result beat out.
// Most events pass through the capture register, the EXEC state and the output register; an apply
// that scales by load also passes through the multiplies and a 39-step serial load division.
// One event is worked on at a time; the next is accepted in the cycle after the
// result is registered, and a full output register holds back the commit.
// Asynchronous active-low reset clears state and config to defaults.
module load_based_dvfs_governor
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lbdg_pkg::IDX_W-1:0]        cfg_index,
    input  logic [lbdg_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // idle_us[31:0], wall_us[63:32], runnable_tasks[71:64], current_freq[93:72]
    input  logic [lbdg_pkg::IN_W-1:0]         s_axis_tdata,
    // command[2:0]
    input  logic [lbdg_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // request_valid[0], request_freq[22:1], relation[23], work_queued[25:24],
    // rearm_timer[26]
    output logic [lbdg_pkg::OUT_W-1:0]        m_axis_tdata
);

    lbdg_pkg::ctrl_cmd_t  ctl;
    lbdg_pkg::dp_status_t status;

    lbdg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .ctl      (ctl)
    );

    lbdg_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .ctl       (ctl),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the load-based DVFS governor.
// Depends on lbdg_pkg and load_based_dvfs_governor; drives event beats and
// checks every result beat against a built-in model of the governor.
module testbench;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] idle;
        logic [31:0] wall;
        logic [7:0]  tasks;
        logic [21:0] cur;
    } event_t;

    typedef struct packed {
        logic        rv;
        logic [21:0] rf;
        logic        rel;
        logic [1:0]  wq;
        logic        rearm;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    load_based_dvfs_governor dut (.*);

    // Governor settings and state mirrored in the testbench.
    logic [21:0] g_min, g_max, g_thresh, g_resume, g_susp, g_guard;
    logic [31:0] g_dwell;
    logic        m_ramp, m_susp, m_armed, m_pending;
    logic [21:0] m_target;
    logic [31:0] m_idle_snap, m_exit_stamp, m_chg_stamp, m_chg_idle;

    event_t  pending_events[$];
    answer_t expected_answers[$];
    int      mismatches;
    int      burst_left;
    int      gap_left;
    int      stall_phase;

    always #5 clk = ~clk;

    // Load-scaled frequency since the last change.
    function automatic logic [21:0] scale_by_load(logic [31:0] idle, logic [31:0] wall,
                                                  logic [21:0] cur);
        logic [31:0] didle, dwall;
        logic [63:0] load;
        didle = idle - m_chg_idle;
        dwall = wall - m_chg_stamp;
        if (dwall == 0)
            load = 100;
        else if (didle >= dwall)
            load = 0;
        else
            load = (64'd100 * (dwall - didle)) / dwall;
        return 22'((64'(cur) * load) / 100);
    endfunction

    // Advances the governor state by one event and returns its result.
    function automatic answer_t governor_step(event_t e);
        answer_t a;
        a = '0;
        case (e.cmd)
            lbdg_pkg::CMD_SAMPLE:
            begin
                m_armed = 0;
                if (e.wall != m_exit_stamp)
                begin
                    if (e.idle - m_idle_snap == 0)
                    begin
                        if (e.cur != g_max && e.tasks >= 1)
                        begin
                            if (g_max > g_thresh)
                            begin
                                if (m_ramp)
                                begin
                                    m_target = g_max;
                                    m_ramp = 0;
                                end
                                else
                                begin
                                    m_ramp = 1;
                                    m_target = g_thresh;
                                end
                            end
                            else
                                m_target = g_max;
                            if (!m_pending) a.wq = lbdg_pkg::WQ_UP;
                            m_pending = 1;
                        end
                    end
                    else
                    begin
                        m_ramp = 0;
                        if (e.tasks > 0)
                        begin
                            m_idle_snap = e.idle;
                            m_exit_stamp = e.wall;
                            m_armed = 1;
                            a.rearm = 1;
                        end
                        if (e.cur != g_min && e.wall - m_chg_stamp >= g_dwell)
                        begin
                            m_target = g_min;
                            if (!m_pending) a.wq = lbdg_pkg::WQ_DOWN;
                            m_pending = 1;
                        end
                    end
                end
            end
            lbdg_pkg::CMD_APPLY:
            if (m_pending)
            begin
                if (!m_susp && (m_target >= g_thresh || m_target == g_max))
                begin
                    if (e.cur < g_guard) m_target = g_resume;
                    if (e.tasks == 1)
                    begin
                        m_pending = 0;
                        return a;
                    end
                    a.rv = 1; a.rf = m_target; a.rel = lbdg_pkg::REL_H;
                end
                else if (!m_susp)
                begin
                    m_target = scale_by_load(e.idle, e.wall, e.cur);
                    a.rv = 1; a.rf = m_target; a.rel = lbdg_pkg::REL_L;
                end
                else if (m_target > g_susp)
                begin
                    a.rv = 1; a.rf = g_susp; a.rel = lbdg_pkg::REL_H;
                end
                else
                begin
                    m_target = scale_by_load(e.idle, e.wall, e.cur);
                    if (m_target < e.cur)
                    begin
                        a.rv = 1; a.rf = m_target; a.rel = lbdg_pkg::REL_H;
                    end
                end
                m_chg_idle = e.idle;
                m_chg_stamp = e.wall;
                m_pending = 0;
            end
            lbdg_pkg::CMD_IDLE_EXIT:
            if (!m_armed)
            begin
                m_idle_snap = e.idle;
                m_exit_stamp = e.wall;
                m_armed = 1;
                a.rearm = 1;
            end
            lbdg_pkg::CMD_SUSPEND:
            begin
                m_susp = 1;
                a.rv = 1; a.rf = g_susp; a.rel = lbdg_pkg::REL_H;
            end
            lbdg_pkg::CMD_RESUME:
            begin
                m_susp = 0;
                a.rv = 1; a.rf = g_resume; a.rel = lbdg_pkg::REL_L;
            end
            lbdg_pkg::CMD_LIMITS:
            if (g_max < e.cur)
            begin
                a.rv = 1; a.rf = g_max; a.rel = lbdg_pkg::REL_H;
            end
            else if (g_min > e.cur)
            begin
                a.rv = 1; a.rf = g_min; a.rel = lbdg_pkg::REL_L;
            end
            default: ;
        endcase
        return a;
    endfunction

    // Writes one register on the port and in the mirror; the block must be idle.
    task automatic write_register(lbdg_pkg::cfg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            lbdg_pkg::CFG_POLICY_MIN:  g_min = value[21:0];
            lbdg_pkg::CFG_POLICY_MAX:  g_max = value[21:0];
            lbdg_pkg::CFG_RAMP_THRESH: g_thresh = value[21:0];
            lbdg_pkg::CFG_RESUME_FREQ: g_resume = value[21:0];
            lbdg_pkg::CFG_SUSP_FREQ:   g_susp = value[21:0];
            lbdg_pkg::CFG_MIN_DWELL:   g_dwell = value;
            lbdg_pkg::CFG_LOW_GUARD:   g_guard = value[21:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || expected_answers.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic event_t random_event(logic [31:0] idle, logic [31:0] wall);
        event_t e;
        e.cmd = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 90)
            e.cmd = ($urandom_range(0, 2) != 0) ? 3'($urandom_range(0, 2))
                                                 : 3'($urandom_range(3, 5));
        e.idle = idle;
        e.wall = wall;
        e.tasks = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        e.cur = 22'($urandom);
        if ($urandom_range(0, 4) == 0)
            e.cur = ($urandom_range(0, 1) != 0) ? g_max : g_min;
        return e;
    endfunction

    // Sender: bursts of beats separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        event_t e;
        if (!rst_n)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_answers.push_back(governor_step(event_t'({s_axis_tuser,
                    s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[71:64],
                    s_axis_tdata[93:72]})));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 0;
            end
            else if (pending_events.size() != 0)
            begin
                e = pending_events.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tuser <= e.cmd;
                s_axis_tdata <= {2'b0, e.cur, e.tasks, e.wall, e.idle};
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 0;
        end
    end

    // Receiver: stalls at random outside a rotating always-ready window and checks each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t want, got;
        if (!rst_n)
        begin
            m_axis_tready <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0)
                m_axis_tready <= 1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[0], m_axis_tdata[22:1], m_axis_tdata[23],
                       m_axis_tdata[25:24], m_axis_tdata[26]};
                if (expected_answers.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("Unexpected result beat %h", got);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got !== want || m_axis_tdata[31:27] !== 0)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display({"Mismatch: rv %0d/%0d freq %0d/%0d rel %0d/%0d",
                                      " wq %0d/%0d rearm %0d/%0d"},
                                     want.rv, got.rv, want.rf, got.rf, want.rel, got.rel,
                                     want.wq, got.wq, want.rearm, got.rearm);
                    end
                end
            end
        end
    end

    // Stimulus: directed events, then phases of realistic random traffic.
    initial
    begin
        event_t      e;
        logic [31:0] idle, wall;
        int          phase;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = lbdg_pkg::CFG_POLICY_MIN;
        cfg_data = 0;
        mismatches = 0;
        g_min = lbdg_pkg::RST_POLICY_MIN;
        g_max = lbdg_pkg::RST_POLICY_MAX;
        g_thresh = lbdg_pkg::RST_RAMP_THRESH;
        g_resume = lbdg_pkg::RST_RESUME_FREQ;
        g_susp = lbdg_pkg::RST_SUSP_FREQ;
        g_dwell = lbdg_pkg::RST_MIN_DWELL;
        g_guard = lbdg_pkg::RST_LOW_GUARD;
        {m_ramp, m_susp, m_armed, m_pending} = '0;
        m_target = 0;
        {m_idle_snap, m_exit_stamp, m_chg_stamp, m_chg_idle} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: extremes, every command, unknown commands, both ramp steps.
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd0, 32'd0, 8'd1, 22'd1000});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd0, 32'd10, 8'd2, 22'd1000});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd0, 32'd20, 8'd2, 22'd1000});
        pending_events.push_back('{lbdg_pkg::CMD_APPLY, 32'd0, 32'd30, 8'd1, 22'd1000});
        pending_events.push_back('{lbdg_pkg::CMD_APPLY, 32'd0, 32'd30, 8'd2, 22'd1000});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd0, 32'd40, 8'd3, 22'd500000});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd0, 32'd50, 8'd0, 22'd500000});
        pending_events.push_back('{lbdg_pkg::CMD_APPLY, 32'd0, 32'd60, 8'd2, 22'd500000});
        pending_events.push_back('{lbdg_pkg::CMD_IDLE_EXIT, 32'd5, 32'd70, 8'd1, 22'd0});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd5, 32'd70, 8'd1, 22'd0});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd90000, 32'd100000, 8'd1,
                                   22'd3000000});
        pending_events.push_back('{lbdg_pkg::CMD_APPLY, 32'd95000, 32'd100000, 8'd1,
                                   22'h3FFFFF});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255,
                                   22'h3FFFFF});
        pending_events.push_back('{lbdg_pkg::CMD_APPLY, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255,
                                   22'h3FFFFF});
        pending_events.push_back('{lbdg_pkg::CMD_SUSPEND, 32'd0, 32'd0, 8'd0, 22'd0});
        pending_events.push_back('{lbdg_pkg::CMD_SAMPLE, 32'd1, 32'd5, 8'd4, 22'd200});
        pending_events.push_back('{lbdg_pkg::CMD_APPLY, 32'd1, 32'd5, 8'd4, 22'd200});
        pending_events.push_back('{lbdg_pkg::CMD_RESUME, 32'd0, 32'd0, 8'd0, 22'd0});
        pending_events.push_back('{lbdg_pkg::CMD_LIMITS, 32'd0, 32'd0, 8'd0, 22'h3FFFFF});
        pending_events.push_back('{lbdg_pkg::CMD_LIMITS, 32'd0, 32'd0, 8'd0, 22'd0});
        pending_events.push_back('{3'd6, 32'hFFFFFFFF, 32'd1, 8'd1, 22'd1});
        pending_events.push_back('{3'd7, 32'd1, 32'hFFFFFFFF, 8'd1, 22'd1});
        wait_drained();

        // Random phases, each after fresh writes to some or all registers.
        idle = $urandom;
        wall = $urandom;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(lbdg_pkg::CFG_POLICY_MIN, 32'd300000);
                    write_register(lbdg_pkg::CFG_POLICY_MAX, 32'd1500000);
                end
                1:
                begin
                    write_register(lbdg_pkg::CFG_POLICY_MIN, 32'd0);
                    write_register(lbdg_pkg::CFG_POLICY_MAX, 32'h3FFFFF);
                    write_register(lbdg_pkg::CFG_RAMP_THRESH, 32'h3FFFFF);
                    write_register(lbdg_pkg::CFG_MIN_DWELL, 32'd0);
                end
                2:
                begin
                    write_register(lbdg_pkg::CFG_POLICY_MAX, 32'd0);
                    write_register(lbdg_pkg::CFG_RAMP_THRESH, 32'd0);
                    write_register(lbdg_pkg::CFG_RESUME_FREQ, 32'h3FFFFF);
                    write_register(lbdg_pkg::CFG_SUSP_FREQ, 32'd0);
                    write_register(lbdg_pkg::CFG_LOW_GUARD, 32'h3FFFFF);
                    write_register(lbdg_pkg::CFG_MIN_DWELL, 32'hFFFFFFFF);
                end
                default:
                begin
                    write_register(lbdg_pkg::CFG_POLICY_MIN, $urandom);
                    write_register(lbdg_pkg::CFG_POLICY_MAX, $urandom);
                    write_register(lbdg_pkg::CFG_RAMP_THRESH, $urandom);
                    write_register(lbdg_pkg::CFG_RESUME_FREQ, $urandom);
                    write_register(lbdg_pkg::CFG_SUSP_FREQ, $urandom);
                    write_register(lbdg_pkg::CFG_MIN_DWELL, $urandom_range(0, 100000));
                    write_register(lbdg_pkg::CFG_LOW_GUARD, $urandom);
                end
            endcase
            repeat (150)
            begin
                // Mostly monotonic time, sometimes a busy tick, rarely a jump.
                wall = wall + $urandom_range(0, 30000);
                if ($urandom_range(0, 2) != 0) idle = idle + $urandom_range(0, 30000);
                if ($urandom_range(0, 30) == 0) {idle, wall} = {$urandom, $urandom};
                pending_events.push_back(random_event(idle, wall));
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end
endmodule
